FILE: hdl/fdl_pkg.sv
// fdl_pkg: shared constants, types and helpers of the fractional delay line
// no dependencies; imported by every module under hdl/

package fdl_pkg;

  // sample store geometry
  localparam int SAMPLE_BITS = 24;
  localparam int MAX_LENGTH  = 65536;
  localparam int RING_EXTRA  = 4;
  localparam int DEPTH       = MAX_LENGTH + RING_EXTRA;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int NUM_TAPS    = 4;
  localparam int TAP_CNT_W   = $clog2(NUM_TAPS);

  // delay arithmetic
  localparam int DELAY_W    = 40;
  localparam int SPM_W      = 24;
  localparam int FRAC_BITS  = 16;
  localparam int GUARD_BITS = 40 - SAMPLE_BITS;
  localparam int DPOS_W     = DELAY_W - 1;
  localparam int MUL_LO_W   = (DPOS_W + 1) / 2;
  localparam int MUL_HI_W   = DPOS_W - MUL_LO_W;
  localparam int PROD_W     = DPOS_W + SPM_W;
  localparam int DQ_W       = PROD_W - FRAC_BITS;

  // interpolation datapath
  localparam int COEF_W    = SAMPLE_BITS + 4;
  localparam int SHIFT_MAX = (GUARD_BITS > FRAC_BITS) ? GUARD_BITS : FRAC_BITS;
  localparam int ACC_W     = SAMPLE_BITS + SHIFT_MAX + 8;
  localparam int STEP_W    = 2;

  // configuration port
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int LEN_FIELD_W = 17;

  localparam logic             TIME_IN_MS_RST = 1'b1;
  localparam logic [SPM_W-1:0] SPM_RST        = SPM_W'(2890138);
  localparam int               BUF_LEN_RST    = 44100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_IN_MS     = 3'd0,
    CFG_SAMPLES_PER_MS = 3'd1,
    CFG_BUFFER_LENGTH  = 3'd2,
    CFG_FREEZE_ON      = 3'd3
  } cfg_idx_t;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // delay unit result: integer tap offset and interpolation fraction
  typedef struct packed {
    logic                 lin;
    logic [ADDR_W-1:0]    idel;
    logic [FRAC_BITS-1:0] frac;
  } dly_res_t;

  // interpolator launch
  typedef struct packed {
    logic                 start;
    logic                 lin;
    logic [FRAC_BITS-1:0] frac;
  } itp_cmd_t;

  function automatic logic [ADDR_W-1:0] clamp_length(input logic [LEN_FIELD_W-1:0] v);
    if (v == '0) begin
      return ADDR_W'(1);
    end
    if (int'(v) > MAX_LENGTH) begin
      return ADDR_W'(MAX_LENGTH);
    end
    return ADDR_W'(v);
  endfunction

endpackage

FILE: hdl/fractional_delay_line.sv
// fractional_delay_line: top level, sequencer around the sample store
// depends on fdl_pkg, fdl_ram, fdl_delay and fdl_interp

// One-channel fractional delay line with linear or cubic interpolation.
// in_*  : one transaction per sample (in_cmd = sample) or store clear
//         (in_cmd = clear). A sample transaction gives exactly one result on
//         out_*, a clear transaction gives none.
// cfg_* : register writes, always ready. Writing buffer_length also clears
//         the store and restarts the write position at zero.
// Flow: a sample transaction passes the delay unit (two multiplier passes),
//   four tap reads on the single store read port and one Horner step of the
//   interpolator for delays below one sample, three otherwise; the next
//   transaction is accepted in the cycle the result appears.
// Clear: a sweep writes zero to all 65540 store entries, one per cycle, and
//   in_ready stays low for that time. The same sweep runs after reset and
//   after a buffer_length write.
// Stall: the result sits in an output register; the block takes the next
//   sample while it waits and only holds its own finished result until
//   out_ready frees the register.

module fractional_delay_line import fdl_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  // sample channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  input  logic signed [DELAY_W-1:0]     in_delay_time,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  typedef enum logic [7:0] {
    S_CLR  = 8'b00000001,  // zero sweep over the store
    S_IDLE = 8'b00000010,  // waiting for a transaction
    S_DLY  = 8'b00000100,  // delay unit busy
    S_RD   = 8'b00001000,  // issuing the four tap reads
    S_LAST = 8'b00010000,  // last tap data returning
    S_GO   = 8'b00100000,  // launch interpolator
    S_CALC = 8'b01000000,  // interpolator busy
    S_OUT  = 8'b10000000   // result waiting for the output register
  } seq_state_t;

  seq_state_t state_r, state_nxt;

  // configuration registers
  logic              time_in_ms_r;
  logic [SPM_W-1:0]  spm_r;
  logic [ADDR_W-1:0] buf_len_r;
  logic              freeze_r;

  // sequencer registers
  logic [ADDR_W-1:0] wp_r, wp_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [ADDR_W-1:0] rd_addr_r;
  logic [TAP_CNT_W-1:0] tcnt_r;
  logic              rdv_r;
  logic [NUM_TAPS-1:0][SAMPLE_BITS-1:0] taps_r;
  logic              out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0] out_sample_r;

  logic              accept, cfg_wr, len_wr, load;
  logic [ADDR_W-1:0] ring_len, ring_last;
  logic [ADDR_W:0]   base_diff;
  logic [ADDR_W-1:0] base_addr;

  // store ports
  logic                   mem_we, mem_re;
  logic [ADDR_W-1:0]      mem_waddr;
  logic [SAMPLE_BITS-1:0] mem_wdata, mem_rdata;

  // unit links
  logic     dly_start, dly_done, itp_done;
  dly_res_t dly_res;
  itp_cmd_t itp_cmd;
  logic [SAMPLE_BITS-1:0] itp_sample;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign len_wr    = cfg_wr && (cfg_index == CFG_BUFFER_LENGTH);

  assign ring_len  = buf_len_r + ADDR_W'(RING_EXTRA);
  assign ring_last = ring_len - ADDR_W'(1);

  // newest tap: write position minus integer delay, modulo the ring
  assign base_diff = {1'b0, wp_r} - {1'b0, dly_res.idel};
  assign base_addr = base_diff[ADDR_W] ? (base_diff[ADDR_W-1:0] + ring_len)
                                       : base_diff[ADDR_W-1:0];

  // the finished result moves into the output register once it is free
  assign load = ((state_r == S_CALC && itp_done) || state_r == S_OUT) &&
                (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:   if (clr_cnt_r == ADDR_W'(DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (accept) state_nxt = (in_cmd == CMD_CLEAR) ? S_CLR : S_DLY;
      S_DLY:   if (dly_done) state_nxt = S_RD;
      S_RD:    if (tcnt_r == TAP_CNT_W'(NUM_TAPS - 1)) state_nxt = S_LAST;
      S_LAST:  state_nxt = S_GO;
      S_GO:    state_nxt = S_CALC;
      S_CALC:  if (itp_done) state_nxt = load ? S_IDLE : S_OUT;
      S_OUT:   if (load) state_nxt = S_IDLE;
      default: state_nxt = S_CLR;
    endcase
    if (len_wr) begin
      state_nxt = S_CLR;
    end
  end

  always_comb begin
    clr_cnt_nxt = clr_cnt_r;
    if (state_r == S_CLR) begin
      clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
    end
    if (state_nxt == S_CLR && (state_r != S_CLR || len_wr)) begin
      clr_cnt_nxt = '0;
    end
  end

  always_comb begin
    wp_nxt = wp_r;
    if (state_r == S_DLY && dly_done) begin
      wp_nxt = (wp_r == ring_last) ? '0 : (wp_r + ADDR_W'(1));
    end
    if (len_wr) begin
      wp_nxt = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_cnt_r    <= '0;
      wp_r         <= '0;
      out_valid_r  <= 1'b0;
      rdv_r        <= 1'b0;
      tcnt_r       <= '0;
      time_in_ms_r <= TIME_IN_MS_RST;
      spm_r        <= SPM_RST;
      buf_len_r    <= ADDR_W'(BUF_LEN_RST);
      freeze_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      wp_r        <= wp_nxt;
      out_valid_r <= out_valid_nxt;
      rdv_r       <= (state_r == S_RD);
      if (state_r == S_RD) begin
        tcnt_r <= tcnt_r + TAP_CNT_W'(1);
      end else begin
        tcnt_r <= '0;
      end
      if (cfg_wr) begin
        case (cfg_index)
          CFG_TIME_IN_MS:     time_in_ms_r <= cfg_data[0];
          CFG_SAMPLES_PER_MS: spm_r        <= cfg_data[SPM_W-1:0];
          CFG_BUFFER_LENGTH:  buf_len_r    <= clamp_length(cfg_data[LEN_FIELD_W-1:0]);
          CFG_FREEZE_ON:      freeze_r     <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_DLY && dly_done) begin
      rd_addr_r <= base_addr;
    end else if (state_r == S_RD) begin
      rd_addr_r <= (rd_addr_r == '0) ? ring_last : (rd_addr_r - ADDR_W'(1));
    end
    // taps shift in oldest-last: after four reads taps_r[0] is the newest
    if (rdv_r) begin
      taps_r <= {mem_rdata, taps_r[NUM_TAPS-1:1]};
    end
    if (load) begin
      out_sample_r <= itp_sample;
    end
  end

  // store: sweep writes zero, unfrozen samples write at the write position
  assign mem_we    = (state_r == S_CLR) ||
                     (accept && in_cmd == CMD_SAMPLE && !freeze_r);
  assign mem_waddr = (state_r == S_CLR) ? clr_cnt_r : wp_r;
  assign mem_wdata = (state_r == S_CLR) ? '0 : in_sample_in;
  assign mem_re    = (state_r == S_RD);

  fdl_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (rd_addr_r),
    .rdata (mem_rdata)
  );

  assign dly_start = accept && (in_cmd == CMD_SAMPLE);

  fdl_delay u_delay (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (dly_start),
    .delay_time     (in_delay_time),
    .time_in_ms     (time_in_ms_r),
    .samples_per_ms (spm_r),
    .buf_len        (buf_len_r),
    .done           (dly_done),
    .res            (dly_res)
  );

  assign itp_cmd.start = (state_r == S_GO);
  assign itp_cmd.lin   = dly_res.lin;
  assign itp_cmd.frac  = dly_res.frac;

  fdl_interp u_interp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (itp_cmd),
    .taps   (taps_r),
    .done   (itp_done),
    .sample (itp_sample)
  );

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

`ifndef SYNTH
  a_wp_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r < ring_len)
    else $error("write position outside the ring");

  a_rd_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> (rd_addr_r < ring_len))
    else $error("tap read address outside the ring");

  a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd == CMD_CLEAR && !len_wr) |=> (state_r == S_CLR && clr_cnt_r == '0))
    else $error("clear transaction did not start a sweep from zero");

  a_dly_done_seq: assert property (@(posedge clk) disable iff (!rst_n)
    dly_done |-> (state_r == S_DLY))
    else $error("delay result outside the delay phase");

  a_itp_done_seq: assert property (@(posedge clk) disable iff (!rst_n)
    itp_done |-> (state_r == S_CALC))
    else $error("interpolator result outside the compute phase");
`endif

endmodule

FILE: hdl/fdl_ram.sv
// fdl_ram: sample store, one write port and one registered read port
// depends on fdl_pkg for depth and word width

module fdl_ram import fdl_pkg::*; (
  input  logic                   clk,
  input  logic                   we,
  input  logic [ADDR_W-1:0]      waddr,
  input  logic [SAMPLE_BITS-1:0] wdata,
  input  logic                   re,
  input  logic [ADDR_W-1:0]      raddr,
  output logic [SAMPLE_BITS-1:0] rdata
);

  logic [SAMPLE_BITS-1:0] mem [DEPTH];
  logic [SAMPLE_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/fdl_delay.sv
// fdl_delay: converts the requested delay into tap offset and fraction
// depends on fdl_pkg; one shared 20x24 multiplier used in two passes

module fdl_delay import fdl_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [DELAY_W-1:0] delay_time,
  input  logic                      time_in_ms,
  input  logic [SPM_W-1:0]          samples_per_ms,
  input  logic [ADDR_W-1:0]         buf_len,
  output logic                      done,
  output dly_res_t                  res
);

  typedef enum logic [4:0] {
    D_IDLE  = 5'b00001,
    D_LO    = 5'b00010,
    D_HI    = 5'b00100,
    D_SUM   = 5'b01000,
    D_CLAMP = 5'b10000
  } dly_state_t;

  localparam int MUL_P_W = MUL_LO_W + SPM_W;
  localparam int DCL_W   = ADDR_W + FRAC_BITS;

  dly_state_t state_r, state_nxt;
  logic                done_r;
  logic [DPOS_W-1:0]   dpos_r;
  logic                ms_r;
  logic [MUL_P_W-1:0]  plo_r, phi_r;
  logic [DQ_W-1:0]     dq_r, dq_nxt;
  dly_res_t            res_r;

  logic [MUL_LO_W-1:0] mul_a;
  logic [MUL_P_W-1:0]  mul_p;
  logic [PROD_W-1:0]   prod_sum;
  logic                lin;
  logic [DQ_W-1:0]     dsub;
  logic [DCL_W-1:0]    maxd, dcl;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      D_IDLE:  if (start) state_nxt = D_LO;
      D_LO:    state_nxt = D_HI;
      D_HI:    state_nxt = D_SUM;
      D_SUM:   state_nxt = D_CLAMP;
      D_CLAMP: state_nxt = D_IDLE;
      default: state_nxt = D_IDLE;
    endcase
  end

  // low half of the delay first, then the high half
  assign mul_a = (state_r == D_LO) ? dpos_r[MUL_LO_W-1:0]
                                   : MUL_LO_W'(dpos_r[DPOS_W-1:MUL_LO_W]);
  assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(samples_per_ms);

  assign prod_sum = PROD_W'(plo_r) + (PROD_W'(phi_r) << MUL_LO_W);
  assign dq_nxt   = ms_r ? prod_sum[PROD_W-1:FRAC_BITS] : DQ_W'(dpos_r);

  // below one sample: linear mode; otherwise step back one sample
  assign lin  = (dq_r[DQ_W-1:FRAC_BITS] == '0);
  assign dsub = lin ? dq_r : (dq_r - (DQ_W'(1) << FRAC_BITS));
  assign maxd = {buf_len - ADDR_W'(1), {FRAC_BITS{1'b0}}};
  assign dcl  = (dsub > DQ_W'(maxd)) ? maxd : dsub[DCL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == D_CLAMP);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == D_IDLE && start) begin
      dpos_r <= delay_time[DELAY_W-1] ? '0 : delay_time[DPOS_W-1:0];
      ms_r   <= time_in_ms;
    end
    if (state_r == D_LO) begin
      plo_r <= mul_p;
    end
    if (state_r == D_HI) begin
      phi_r <= mul_p;
    end
    if (state_r == D_SUM) begin
      dq_r <= dq_nxt;
    end
    if (state_r == D_CLAMP) begin
      res_r.lin  <= lin;
      res_r.idel <= dcl[DCL_W-1:FRAC_BITS];
      res_r.frac <= dcl[FRAC_BITS-1:0];
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

FILE: hdl/fdl_interp.sv
// fdl_interp: linear or cubic interpolation of four taps by Horner steps
// depends on fdl_pkg; one shared multiply-accumulate step per cycle

module fdl_interp import fdl_pkg::*; (
  input  logic                                clk,
  input  logic                                rst_n,
  input  itp_cmd_t                            cmd,
  input  logic [NUM_TAPS-1:0][SAMPLE_BITS-1:0] taps,
  output logic                                done,
  output logic [SAMPLE_BITS-1:0]              sample
);

  typedef enum logic [3:0] {
    I_IDLE  = 4'b0001,
    I_PREP  = 4'b0010,
    I_STEP  = 4'b0100,
    I_ROUND = 4'b1000
  } itp_state_t;

  localparam logic signed [ACC_W-1:0] RND_LIN = ACC_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] RND_CUB = ACC_W'(1) <<< GUARD_BITS;
  localparam logic signed [ACC_W-1:0] SAT_HI  =
    {{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO  = ~SAT_HI;

  itp_state_t state_r, state_nxt;
  logic                          done_r;
  logic                          lin_r;
  logic [FRAC_BITS-1:0]          frac_r;
  logic signed [SAMPLE_BITS-1:0] ta_r, tb_r, tc_r, te_r;
  logic signed [COEF_W-1:0]      add0_r, add1_r, add2_r;
  logic [STEP_W-1:0]             steps_r;
  logic signed [ACC_W-1:0]       acc_r;
  logic [SAMPLE_BITS-1:0]        sample_r;

  logic signed [COEF_W-1:0]          wa, wb, wc, we, bc, c2, c3;
  logic signed [ACC_W-FRAC_BITS-1:0] vh;
  logic [FRAC_BITS-1:0]              vl;
  logic signed [ACC_W:0]             ph;
  logic [2*FRAC_BITS-1:0]            pl;
  logic signed [ACC_W-1:0]           horner, rnd, sat;

  function automatic logic signed [ACC_W-1:0] scale(input logic signed [COEF_W-1:0] x,
                                                    input logic lin);
    logic signed [ACC_W-1:0] w;
    w = ACC_W'(x);
    return lin ? (w <<< FRAC_BITS) : (w <<< GUARD_BITS);
  endfunction

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      I_IDLE:  if (cmd.start) state_nxt = I_PREP;
      I_PREP:  state_nxt = I_STEP;
      I_STEP:  if (steps_r == STEP_W'(1)) state_nxt = I_ROUND;
      I_ROUND: state_nxt = I_IDLE;
      default: state_nxt = I_IDLE;
    endcase
  end

  // catmull-rom coefficients, doubled
  assign wa = COEF_W'(ta_r);
  assign wb = COEF_W'(tb_r);
  assign wc = COEF_W'(tc_r);
  assign we = COEF_W'(te_r);
  assign bc = wb - wc;
  assign c2 = (wa <<< 1) - (wb <<< 2) - wb + (wc <<< 2) - we;
  assign c3 = we - wa + bc + (bc <<< 1);

  // floor(acc * t / 2^16) split into a signed high part and an unsigned low part
  assign vh = acc_r[ACC_W-1:FRAC_BITS];
  assign vl = acc_r[FRAC_BITS-1:0];
  assign ph = vh * $signed({1'b0, frac_r});
  assign pl = vl * frac_r;
  assign horner = ACC_W'(ph) + ACC_W'($signed({1'b0, pl[2*FRAC_BITS-1:FRAC_BITS]}));

  assign rnd = lin_r ? ((acc_r + RND_LIN) >>> FRAC_BITS)
                     : ((acc_r + RND_CUB) >>> (GUARD_BITS + 1));
  assign sat = (rnd > SAT_HI) ? SAT_HI : ((rnd < SAT_LO) ? SAT_LO : rnd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= I_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == I_ROUND);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == I_IDLE && cmd.start) begin
      lin_r  <= cmd.lin;
      frac_r <= cmd.frac;
      ta_r   <= taps[0];
      tb_r   <= taps[1];
      tc_r   <= taps[2];
      te_r   <= taps[3];
    end
    if (state_r == I_PREP) begin
      acc_r   <= lin_r ? scale(wb - wa, 1'b1) : scale(c3, 1'b0);
      add0_r  <= lin_r ? wa : c2;
      add1_r  <= wc - wa;
      add2_r  <= wb <<< 1;
      steps_r <= lin_r ? STEP_W'(1) : STEP_W'(NUM_TAPS - 1);
    end
    if (state_r == I_STEP) begin
      acc_r   <= horner + scale(add0_r, lin_r);
      add0_r  <= add1_r;
      add1_r  <= add2_r;
      steps_r <= steps_r - STEP_W'(1);
    end
    if (state_r == I_ROUND) begin
      sample_r <= sat[SAMPLE_BITS-1:0];
    end
  end

  assign done   = done_r;
  assign sample = sample_r;

endmodule
